// ----- design/lpps_pkg.sv -----
// Shared widths, constants and types of the line-position PID steering block.
package lpps_pkg;

  localparam int unsigned MARGIN_W  = 12;
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned ERR_W     = 14;
  localparam int unsigned OPND_W    = 15;
  localparam int unsigned PROD_W    = 31;
  localparam int unsigned ACC_W     = 32;
  localparam int unsigned CORR_W    = 25;
  localparam int unsigned QUOT_W    = 10;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [MARGIN_W-1:0]     MARGIN_RST = 12'd400;
  // +-2.5 position times ten, Q.8
  localparam logic signed [ERR_W-1:0] LOST_ERR   = 14'sd6400;
  // +-30.0, Q.8
  localparam logic signed [ERR_W-1:0] INTEG_LIM  = 14'sd7680;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MARGIN = 2'd0,
    CFG_PROP   = 2'd1,
    CFG_INTEG  = 2'd2,
    CFG_DERIV  = 2'd3
  } cfg_idx_e;

  typedef logic [GAIN_W-1:0]        gain_t;
  typedef logic signed [OPND_W-1:0] opnd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ----- design/line_position_pid_steering.sv -----
// Top level of the line-position PID steering block.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i/in_ready_o   sensor_a_i..sensor_d_i
//   out      output     out_valid_o/out_ready_i steer_correction_o, scaled_error_o,
//                                               line_lost_o
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Each item passes through these steps in order: forming the weighted sums, the
// bit-serial divider (10 quotient bits, then its done flag), error and integral,
// the bit-serial multiply-accumulate (three 16-bit gains, then its done flag),
// and loading the result.
// A new item is taken once the previous result is loaded into the output register,
// so the block does not take a new item before it is through with the last one.
// A stalled output holds the finished item in the last step until the register frees.
// Reset clears the gains, the margin (to 400), last error and integral.
module line_position_pid_steering #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0]                 sensor_a_i,
  input  logic [SAMPLE_BITS-1:0]                 sensor_b_i,
  input  logic [SAMPLE_BITS-1:0]                 sensor_c_i,
  input  logic [SAMPLE_BITS-1:0]                 sensor_d_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [lpps_pkg::CORR_W-1:0]     steer_correction_o,
  output logic signed [lpps_pkg::ERR_W-1:0]      scaled_error_o,
  output logic                                   line_lost_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [lpps_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [lpps_pkg::GAIN_W-1:0]            cfg_data_i
);

  localparam int unsigned SUM_W = SAMPLE_BITS + 2;
  localparam int unsigned NUM_W = SUM_W + 8;
  localparam int unsigned CMP_W =
    (SAMPLE_BITS > lpps_pkg::MARGIN_W) ? SAMPLE_BITS : lpps_pkg::MARGIN_W;
  localparam int unsigned EW    = lpps_pkg::ERR_W;
  localparam int unsigned OW    = lpps_pkg::OPND_W;
  localparam int unsigned QW    = lpps_pkg::QUOT_W;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PREP = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_ERR  = 6'b001000,
    ST_MAC  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_e;

  state_e                               state_q, state_d;
  logic [SAMPLE_BITS-1:0]               sensor_q [4];
  logic [lpps_pkg::MARGIN_W-1:0]        margin_q;
  lpps_pkg::gain_t                      prop_q, integ_gain_q, deriv_q;
  logic signed [EW-1:0]                 last_error_q;
  logic signed [EW-1:0]                 error_integral_q;
  lpps_pkg::opnd_t                      diff_q;
  logic                                 lost_q;
  logic                                 neg_q;
  logic                                 out_valid_q;
  logic signed [lpps_pkg::CORR_W-1:0]   corr_out_q;
  logic signed [EW-1:0]                 err_out_q;
  logic                                 lost_out_q;

  logic [SUM_W-1:0]                     s_x [4];
  logic [SUM_W-1:0]                     wpos, wneg, wmag, ssum;
  logic                                 seen, wneg_big;
  logic [NUM_W-1:0]                     num;
  logic [QW-1:0]                        quot;
  logic signed [QW:0]                   pos;
  logic signed [EW-1:0]                 pos_x, err_cent, err_val, integ_val;
  lpps_pkg::opnd_t                      diff_val, integ_sum;
  logic signed [lpps_pkg::ACC_W-1:0]    acc;
  lpps_pkg::unit_stat_t                 div_stat, mac_stat;
  logic                                 in_xfer, cfg_xfer, fin_load;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign fin_load    = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  // weighted sums: +3a +b on one side, +c +3d on the other
  always_comb begin
    seen = 1'b0;
    for (int i = 0; i < 4; i++) begin
      s_x[i] = SUM_W'(sensor_q[i]);
      if (CMP_W'(sensor_q[i]) > CMP_W'(margin_q)) begin
        seen = 1'b1;
      end
    end
    wpos     = (s_x[0] << 1) + s_x[0] + s_x[1];
    wneg     = s_x[2] + (s_x[3] << 1) + s_x[3];
    ssum     = s_x[0] + s_x[1] + s_x[2] + s_x[3];
    wneg_big = (wneg > wpos);
    wmag     = wneg_big ? (wneg - wpos) : (wpos - wneg);
    num      = {wmag, 8'b0};
  end

  lpps_div #(
    .NUM_W (NUM_W),
    .DEN_W (SUM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_PREP),
    .num_i   (num),
    .den_i   (ssum),
    .stat_o  (div_stat),
    .quot_o  (quot)
  );

  // truncation toward zero: divide magnitudes, then apply the sign
  always_comb begin
    pos      = neg_q ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    pos_x    = EW'(pos);
    err_cent = (pos_x <<< 3) + (pos_x <<< 1);
    if (lost_q) begin
      err_val = (last_error_q > 0) ? lpps_pkg::LOST_ERR : -lpps_pkg::LOST_ERR;
    end else begin
      err_val = err_cent;
    end
    diff_val  = OW'(err_val) - OW'(last_error_q);
    integ_sum = OW'(error_integral_q) + OW'(err_val);
    if (integ_sum > OW'(lpps_pkg::INTEG_LIM)) begin
      integ_val = lpps_pkg::INTEG_LIM;
    end else if (integ_sum < -OW'(lpps_pkg::INTEG_LIM)) begin
      integ_val = -lpps_pkg::INTEG_LIM;
    end else begin
      integ_val = EW'(integ_sum);
    end
  end

  lpps_mac u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (state_q == ST_ERR),
    .prop_gain_i  (prop_q),
    .integ_gain_i (integ_gain_q),
    .deriv_gain_i (deriv_q),
    .err_i        (OW'(last_error_q)),
    .integ_i      (OW'(error_integral_q)),
    .diff_i       (diff_q),
    .stat_o       (mac_stat),
    .acc_o        (acc)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_PREP;
      ST_PREP: state_d = ST_DIV;
      ST_DIV:  if (div_stat.done) state_d = ST_ERR;
      ST_ERR:  state_d = ST_MAC;
      ST_MAC:  if (mac_stat.done) state_d = ST_FIN;
      ST_FIN:  if (fin_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      margin_q         <= lpps_pkg::MARGIN_RST;
      prop_q           <= '0;
      integ_gain_q     <= '0;
      deriv_q          <= '0;
      last_error_q     <= '0;
      error_integral_q <= '0;
      out_valid_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_xfer) begin
        unique case (lpps_pkg::cfg_idx_e'(cfg_index_i))
          lpps_pkg::CFG_MARGIN: margin_q     <= cfg_data_i[lpps_pkg::MARGIN_W-1:0];
          lpps_pkg::CFG_PROP:   prop_q       <= cfg_data_i;
          lpps_pkg::CFG_INTEG:  integ_gain_q <= cfg_data_i;
          lpps_pkg::CFG_DERIV:  deriv_q      <= cfg_data_i;
        endcase
      end
      if (state_q == ST_ERR) begin
        last_error_q     <= err_val;
        error_integral_q <= integ_val;
      end
      if (fin_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      sensor_q[0] <= sensor_a_i;
      sensor_q[1] <= sensor_b_i;
      sensor_q[2] <= sensor_c_i;
      sensor_q[3] <= sensor_d_i;
    end
    if (state_q == ST_PREP) begin
      lost_q <= !seen;
      neg_q  <= wneg_big;
    end
    if (state_q == ST_ERR) begin
      diff_q <= diff_val;
    end
    if (fin_load) begin
      // Q.16 to Q.8, rounding toward minus infinity
      corr_out_q <= lpps_pkg::CORR_W'(acc >>> 8);
      err_out_q  <= last_error_q;
      lost_out_q <= lost_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign steer_correction_o = corr_out_q;
  assign scaled_error_o     = err_out_q;
  assign line_lost_o        = lost_out_q;

`ifndef SYNTHESIS
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide step");

  a_idle_units_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_stat.busy && !mac_stat.busy)
    else $error("arithmetic unit busy while taking a new item");

  a_integral_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (error_integral_q <= lpps_pkg::INTEG_LIM) && (error_integral_q >= -lpps_pkg::INTEG_LIM))
    else $error("error integral outside its clamp");

  a_lost_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && line_lost_o |->
      scaled_error_o == lpps_pkg::LOST_ERR || scaled_error_o == -lpps_pkg::LOST_ERR)
    else $error("lost-line result with a centroid error");
`endif

endmodule

// ----- design/lpps_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
module lpps_div #(
  parameter int unsigned NUM_W = 22,
  parameter int unsigned DEN_W = 14
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [NUM_W-1:0]               num_i,
  input  logic [DEN_W-1:0]               den_i,
  output lpps_pkg::unit_stat_t           stat_o,
  output logic [lpps_pkg::QUOT_W-1:0]    quot_o
);

  localparam int unsigned QW    = lpps_pkg::QUOT_W;
  localparam int unsigned DSH_W = DEN_W + QW - 1;
  localparam int unsigned REM_W = (NUM_W > DSH_W) ? NUM_W : DSH_W;
  localparam int unsigned CNT_W = $clog2(QW);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QW - 1);

  logic [REM_W-1:0] rem_q;
  logic [DSH_W-1:0] dsh_q;
  logic [QW-1:0]    quot_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [REM_W-1:0] dsh_x;
  logic             fits;

  // quotient is known to stay below 2**QW, so the divisor starts at den << (QW-1)
  assign dsh_x = REM_W'(dsh_q);
  assign fits  = (rem_q >= dsh_x);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= REM_W'(num_i);
      dsh_q <= {den_i, {(QW-1){1'b0}}};
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - dsh_x;
      end
      quot_q <= {quot_q[QW-2:0], fits};
      dsh_q  <= dsh_q >> 1;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;

endmodule

// ----- design/lpps_mac.sv -----
// Bit-serial multiply-accumulate of the three PID terms, one gain bit per cycle apart from an add step after each term.
module lpps_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  lpps_pkg::gain_t                     prop_gain_i,
  input  lpps_pkg::gain_t                     integ_gain_i,
  input  lpps_pkg::gain_t                     deriv_gain_i,
  input  lpps_pkg::opnd_t                     err_i,
  input  lpps_pkg::opnd_t                     integ_i,
  input  lpps_pkg::opnd_t                     diff_i,
  output lpps_pkg::unit_stat_t                stat_o,
  output logic signed [lpps_pkg::ACC_W-1:0]   acc_o
);

  localparam int unsigned GW     = lpps_pkg::GAIN_W;
  localparam int unsigned PW     = lpps_pkg::PROD_W;
  localparam int unsigned AW     = lpps_pkg::ACC_W;
  localparam int unsigned BIT_W  = $clog2(GW);
  localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(GW - 1);

  typedef enum logic [2:0] {
    TERM_P = 3'b001,
    TERM_I = 3'b010,
    TERM_D = 3'b100
  } term_e;

  term_e               term_q;
  logic [BIT_W-1:0]    bit_q;
  logic                busy_q;
  logic                add_q;
  logic                done_q;
  lpps_pkg::gain_t     gsh_q;
  logic signed [PW-1:0] prod_q;
  logic signed [AW-1:0] acc_q;
  lpps_pkg::opnd_t     sel_opnd;
  logic signed [PW-1:0] addend;

  always_comb begin
    case (term_q)
      TERM_P:  sel_opnd = err_i;
      TERM_I:  sel_opnd = integ_i;
      default: sel_opnd = diff_i;
    endcase
  end

  // MSB-first shift-add; the product wraps correctly in two's complement
  assign addend = gsh_q[GW-1] ? PW'(sel_opnd) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      add_q  <= 1'b0;
      done_q <= 1'b0;
      term_q <= TERM_P;
      bit_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        add_q  <= 1'b0;
        term_q <= TERM_P;
        bit_q  <= '0;
      end else if (busy_q) begin
        if (add_q) begin
          add_q <= 1'b0;
          bit_q <= '0;
          unique case (term_q)
            TERM_P:  term_q <= TERM_I;
            TERM_I:  term_q <= TERM_D;
            default: begin
              busy_q <= 1'b0;
              done_q <= 1'b1;
            end
          endcase
        end else begin
          bit_q <= bit_q + 1'b1;
          if (bit_q == BIT_LAST) begin
            add_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      gsh_q  <= prop_gain_i;
      prod_q <= '0;
      acc_q  <= '0;
    end else if (busy_q) begin
      if (add_q) begin
        acc_q  <= acc_q + AW'(prod_q);
        prod_q <= '0;
        case (term_q)
          TERM_P:  gsh_q <= integ_gain_i;
          default: gsh_q <= deriv_gain_i;
        endcase
      end else begin
        prod_q <= (prod_q <<< 1) + addend;
        gsh_q  <= gsh_q << 1;
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign acc_o       = acc_q;

endmodule
